// ----- src/irb_pkg.sv -----
// Shared types and constants for the bilinear image rotation block.
// Used by every module under src; depends on nothing.
package irb_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int FRAC_BITS  = 14;
  localparam int SHIFT_S    = FRAC_BITS + 1;

  localparam int COORD_W  = 8;
  localparam int DIM_W    = 9;
  localparam int ANGLE_W  = 16;
  localparam int RGB_W    = 24;
  localparam int ARGB_W   = 32;
  localparam int REL_W    = 11;
  localparam int PROD_W   = REL_W + ANGLE_W;
  localparam int POS_W    = 30;
  localparam int FLOOR_W  = POS_W - SHIFT_S;
  localparam int WEIGHT_W = SHIFT_S + 1;
  localparam int RSUM_W   = WEIGHT_W + 9;
  localparam int VSUM_W   = WEIGHT_W + RSUM_W + 1;
  localparam int BANK_AW  = 2 * (COORD_W - 1);
  localparam int BANK_DEPTH = 1 << BANK_AW;
  localparam int CFG_IDX_W  = 2;

  localparam logic [WEIGHT_W-1:0] ONE_S = WEIGHT_W'(1 << SHIFT_S);

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COS    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SIN    = 2'd3;

  typedef struct packed {
    logic               op;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [RGB_W-1:0]   rgb;
  } item_t;

  typedef struct packed {
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] y1;
    logic [SHIFT_S-1:0] fx;
    logic [SHIFT_S-1:0] fy;
  } coords_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] wa;
    logic [WEIGHT_W-1:0] wb;
    logic [WEIGHT_W-1:0] wc;
    logic [WEIGHT_W-1:0] wd;
  } weights_t;

  typedef struct packed {
    logic [RGB_W-1:0] p11;
    logic [RGB_W-1:0] p21;
    logic [RGB_W-1:0] p12;
    logic [RGB_W-1:0] p22;
  } pix_t;

endpackage

// ----- src/irb_map.sv -----
// Coordinate mapping: four pipeline stages from output pixel to clamped
// source neighbours and fractions. Depends on irb_pkg.
module irb_map (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                in_valid,
  input  irb_pkg::item_t                      in_item,
  input  logic [irb_pkg::DIM_W-1:0]           width_cfg,
  input  logic [irb_pkg::DIM_W-1:0]           height_cfg,
  input  logic signed [irb_pkg::ANGLE_W-1:0]  cos_cfg,
  input  logic signed [irb_pkg::ANGLE_W-1:0]  sin_cfg,
  output logic                                out_valid,
  output irb_pkg::item_t                      out_item,
  output irb_pkg::coords_t                    out_coords
);

  function automatic logic [irb_pkg::COORD_W-1:0] clamp_coord(
    input logic signed [irb_pkg::FLOOR_W:0] v,
    input logic [irb_pkg::DIM_W-1:0]        lim
  );
    logic signed [irb_pkg::FLOOR_W:0] hi;
    hi = $signed({{(irb_pkg::FLOOR_W + 1 - irb_pkg::DIM_W){1'b0}},
                  lim - irb_pkg::DIM_W'(1)});
    if (v < 0) begin
      clamp_coord = '0;
    end else if (v > hi) begin
      clamp_coord = hi[irb_pkg::COORD_W-1:0];
    end else begin
      clamp_coord = v[irb_pkg::COORD_W-1:0];
    end
  endfunction

  logic                              v1_r, v2_r, v3_r, v4_r;
  irb_pkg::item_t                    item1_r, item2_r, item3_r, item4_r;
  logic signed [irb_pkg::REL_W-1:0]  rx2_r, ry2_r, rx2_nxt, ry2_nxt;
  logic signed [irb_pkg::PROD_W-1:0] pxc_r, pys_r, pxs_r, pyc_r;
  logic signed [irb_pkg::POS_W-1:0]  xs_r, ys_r, xs_nxt, ys_nxt;
  logic signed [irb_pkg::POS_W-1:0]  wterm, hterm;
  logic signed [irb_pkg::FLOOR_W:0]  x0f, y0f, x1f, y1f;
  irb_pkg::coords_t                  coords_r, coords_nxt;

  assign rx2_nxt = $signed({2'b00, in_item.col, 1'b0}) - $signed({2'b00, width_cfg});
  assign ry2_nxt = $signed({2'b00, in_item.row, 1'b0}) + irb_pkg::REL_W'(2)
                   - $signed({2'b00, height_cfg});

  assign wterm = $signed({{(irb_pkg::POS_W - irb_pkg::DIM_W - irb_pkg::FRAC_BITS){1'b0}},
                          width_cfg, {irb_pkg::FRAC_BITS{1'b0}}});
  assign hterm = $signed({{(irb_pkg::POS_W - irb_pkg::DIM_W - irb_pkg::FRAC_BITS){1'b0}},
                          height_cfg, {irb_pkg::FRAC_BITS{1'b0}}});

  assign xs_nxt = irb_pkg::POS_W'(pxc_r) + irb_pkg::POS_W'(pys_r) + wterm;
  assign ys_nxt = irb_pkg::POS_W'(pyc_r) - irb_pkg::POS_W'(pxs_r) + hterm;

  always_comb begin
    x0f = $signed({xs_r[irb_pkg::POS_W-1], xs_r[irb_pkg::POS_W-1:irb_pkg::SHIFT_S]});
    y0f = $signed({ys_r[irb_pkg::POS_W-1], ys_r[irb_pkg::POS_W-1:irb_pkg::SHIFT_S]});
    x1f = x0f + $signed({{irb_pkg::FLOOR_W{1'b0}},
                         (xs_r[irb_pkg::SHIFT_S-1:0] != '0)});
    y1f = y0f + $signed({{irb_pkg::FLOOR_W{1'b0}},
                         (ys_r[irb_pkg::SHIFT_S-1:0] != '0)});
    coords_nxt.x0 = clamp_coord(x0f, width_cfg);
    coords_nxt.x1 = clamp_coord(x1f, width_cfg);
    coords_nxt.y0 = clamp_coord(y0f, height_cfg);
    coords_nxt.y1 = clamp_coord(y1f, height_cfg);
    coords_nxt.fx = xs_r[irb_pkg::SHIFT_S-1:0];
    coords_nxt.fy = ys_r[irb_pkg::SHIFT_S-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item1_r  <= in_item;
      rx2_r    <= rx2_nxt;
      ry2_r    <= ry2_nxt;
      item2_r  <= item1_r;
      pxc_r    <= rx2_r * cos_cfg;
      pys_r    <= ry2_r * sin_cfg;
      pxs_r    <= rx2_r * sin_cfg;
      pyc_r    <= ry2_r * cos_cfg;
      item3_r  <= item2_r;
      xs_r     <= xs_nxt;
      ys_r     <= ys_nxt;
      item4_r  <= item3_r;
      coords_r <= coords_nxt;
    end
  end

  assign out_valid  = v4_r;
  assign out_item   = item4_r;
  assign out_coords = coords_r;

endmodule

// ----- src/irb_fetch.sv -----
// Image store in four banks split by row and column parity, so the four
// neighbours are read in the same cycle; also forms the weights. Depends on irb_pkg.
module irb_fetch (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  irb_pkg::item_t               in_item,
  input  irb_pkg::coords_t             in_coords,
  output logic                         out_valid,
  output logic                         out_op,
  output logic [irb_pkg::COORD_W-1:0]  out_row,
  output logic [irb_pkg::COORD_W-1:0]  out_col,
  output irb_pkg::pix_t                out_pix,
  output irb_pkg::weights_t            out_weights
);

  logic [irb_pkg::BANK_AW-1:0] raddr [4];
  logic [irb_pkg::BANK_AW-1:0] waddr;
  logic [1:0]                  wsel;
  logic [irb_pkg::RGB_W-1:0]   rd_r [4];
  logic [3:0]                  wr_en;
  logic                        v_r, op_r;
  logic [irb_pkg::COORD_W-1:0] row_r, col_r;
  logic                        x0p_r, x1p_r, y0p_r, y1p_r;
  irb_pkg::weights_t           wt_r, wt_nxt;

  assign waddr = {in_item.row[irb_pkg::COORD_W-1:1], in_item.col[irb_pkg::COORD_W-1:1]};
  assign wsel  = {in_item.row[0], in_item.col[0]};

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      logic [irb_pkg::COORD_W-1:0] xsel, ysel;
      xsel = (in_coords.x0[0] == b[0]) ? in_coords.x0 : in_coords.x1;
      ysel = (in_coords.y0[0] == b[1]) ? in_coords.y0 : in_coords.y1;
      raddr[b] = {ysel[irb_pkg::COORD_W-1:1], xsel[irb_pkg::COORD_W-1:1]};
      wr_en[b] = in_valid && (in_item.op == irb_pkg::OP_LOAD) && (wsel == 2'(b));
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_bank
    logic [irb_pkg::RGB_W-1:0] mem [irb_pkg::BANK_DEPTH];
    always_ff @(posedge clk) begin
      if (en) begin
        if (wr_en[g]) begin
          mem[waddr] <= in_item.rgb;
        end
        rd_r[g] <= mem[raddr[g]];
      end
    end
  end

  always_comb begin
    if (in_coords.x0 == in_coords.x1) begin
      wt_nxt.wa = irb_pkg::ONE_S;
      wt_nxt.wb = '0;
    end else begin
      wt_nxt.wa = irb_pkg::ONE_S - {1'b0, in_coords.fx};
      wt_nxt.wb = {1'b0, in_coords.fx};
    end
    if (in_coords.y0 == in_coords.y1) begin
      wt_nxt.wc = irb_pkg::ONE_S;
      wt_nxt.wd = '0;
    end else begin
      wt_nxt.wc = {1'b0, in_coords.fy};
      wt_nxt.wd = irb_pkg::ONE_S - {1'b0, in_coords.fy};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_r  <= in_item.op;
      row_r <= in_item.row;
      col_r <= in_item.col;
      x0p_r <= in_coords.x0[0];
      x1p_r <= in_coords.x1[0];
      y0p_r <= in_coords.y0[0];
      y1p_r <= in_coords.y1[0];
      wt_r  <= wt_nxt;
    end
  end

  assign out_valid   = v_r;
  assign out_op      = op_r;
  assign out_row     = row_r;
  assign out_col     = col_r;
  assign out_pix.p11 = rd_r[{y1p_r, x0p_r}];
  assign out_pix.p21 = rd_r[{y1p_r, x1p_r}];
  assign out_pix.p12 = rd_r[{y0p_r, x0p_r}];
  assign out_pix.p22 = rd_r[{y0p_r, x1p_r}];
  assign out_weights = wt_r;

endmodule

// ----- src/irb_blend.sv -----
// Bilinear mix: horizontal sums in one stage, vertical sum, shift and
// saturation into the output register. Depends on irb_pkg.
module irb_blend (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic                         in_op,
  input  logic [irb_pkg::COORD_W-1:0]  in_row,
  input  logic [irb_pkg::COORD_W-1:0]  in_col,
  input  irb_pkg::pix_t                in_pix,
  input  irb_pkg::weights_t            in_weights,
  output logic                         out_valid,
  output logic [irb_pkg::COORD_W-1:0]  out_row,
  output logic [irb_pkg::COORD_W-1:0]  out_col,
  output logic [irb_pkg::ARGB_W-1:0]   out_argb
);

  logic                         v6_r, op6_r, out_valid_r;
  logic [irb_pkg::COORD_W-1:0]  row6_r, col6_r, row_r, col_r;
  logic [irb_pkg::WEIGHT_W-1:0] wc_r, wd_r;
  logic [irb_pkg::RSUM_W-1:0]   r1_r [3], r2_r [3], r1_nxt [3], r2_nxt [3];
  logic [irb_pkg::ARGB_W-1:0]   argb_r, argb_nxt;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      r1_nxt[k] = irb_pkg::RSUM_W'(in_weights.wa) * irb_pkg::RSUM_W'(in_pix.p11[8*k +: 8])
                + irb_pkg::RSUM_W'(in_weights.wb) * irb_pkg::RSUM_W'(in_pix.p21[8*k +: 8]);
      r2_nxt[k] = irb_pkg::RSUM_W'(in_weights.wa) * irb_pkg::RSUM_W'(in_pix.p12[8*k +: 8])
                + irb_pkg::RSUM_W'(in_weights.wb) * irb_pkg::RSUM_W'(in_pix.p22[8*k +: 8]);
    end
  end

  always_comb begin
    argb_nxt = {8'hff, {irb_pkg::RGB_W{1'b0}}};
    for (int k = 0; k < 3; k++) begin
      logic [irb_pkg::VSUM_W-1:0] vsum;
      logic [irb_pkg::VSUM_W-2*irb_pkg::SHIFT_S-1:0] vq;
      vsum = irb_pkg::VSUM_W'(wc_r) * irb_pkg::VSUM_W'(r1_r[k])
           + irb_pkg::VSUM_W'(wd_r) * irb_pkg::VSUM_W'(r2_r[k]);
      vq = vsum[irb_pkg::VSUM_W-1:2*irb_pkg::SHIFT_S];
      argb_nxt[8*k +: 8] = (vq > 255) ? 8'hff : vq[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v6_r        <= in_valid;
      out_valid_r <= v6_r && (op6_r == irb_pkg::OP_REQUEST);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op6_r  <= in_op;
      row6_r <= in_row;
      col6_r <= in_col;
      wc_r   <= in_weights.wc;
      wd_r   <= in_weights.wd;
      r1_r   <= r1_nxt;
      r2_r   <= r2_nxt;
      row_r  <= row6_r;
      col_r  <= col6_r;
      argb_r <= argb_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_row   = row_r;
  assign out_col   = col_r;
  assign out_argb  = argb_r;

endmodule

// ----- src/image_rotate_bilinear.sv -----
// Top level of the bilinear image rotation block: configuration registers,
// pipeline control and the stream ports. Depends on irb_pkg, irb_map,
// irb_fetch and irb_blend.
//
// Usage: write image_width, image_height, cos_angle and sin_angle on the cfg
// channel (index 0..3) while the block is idle. Send load items (tuser 0) to
// fill the source image, then request items (tuser 1) naming an output row
// and column. Each request gives one output item with the row, the column
// and the ARGB pixel; loads give none and take effect in stream order.
// One item is accepted every cycle while the receiver does not stall; the
// four neighbour reads are served together by four parity banks of the
// image store.
// Reset clears the pipeline valid bits and sets the registers to width 256,
// height 256, cosine 1.0 and sine 0; the image store is not cleared.
// When the receiver stalls, the whole pipeline holds and in_tready drops
// while a result waits in the output register; empty stages hold as well.
module image_rotate_bilinear (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [39:0]                       in_tdata,   // row, col, source_rgb
  input  logic                              in_tuser,   // opcode
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [47:0]                       out_tdata,  // out_row, out_col, out_argb
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [irb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [irb_pkg::ANGLE_W-1:0]       cfg_data
);

  logic [irb_pkg::DIM_W-1:0]          width_r, height_r, width_eff, height_eff;
  logic signed [irb_pkg::ANGLE_W-1:0] cos_r, sin_r;
  logic                               en;
  irb_pkg::item_t                     in_item, map_item;
  irb_pkg::coords_t                   map_coords;
  logic                               map_valid, fet_valid, fet_op;
  logic [irb_pkg::COORD_W-1:0]        fet_row, fet_col, out_row, out_col;
  irb_pkg::pix_t                      fet_pix;
  irb_pkg::weights_t                  fet_wt;
  logic [irb_pkg::ARGB_W-1:0]         out_argb;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= irb_pkg::DIM_W'(irb_pkg::MAX_WIDTH);
      height_r <= irb_pkg::DIM_W'(irb_pkg::MAX_HEIGHT);
      cos_r    <= irb_pkg::ANGLE_W'(1 << irb_pkg::FRAC_BITS);
      sin_r    <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        irb_pkg::CFG_WIDTH:  width_r  <= cfg_data[irb_pkg::DIM_W-1:0];
        irb_pkg::CFG_HEIGHT: height_r <= cfg_data[irb_pkg::DIM_W-1:0];
        irb_pkg::CFG_COS:    cos_r    <= cfg_data;
        irb_pkg::CFG_SIN:    sin_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign width_eff  = (width_r == '0) ? irb_pkg::DIM_W'(1) :
                      (width_r > irb_pkg::DIM_W'(irb_pkg::MAX_WIDTH)) ?
                      irb_pkg::DIM_W'(irb_pkg::MAX_WIDTH) : width_r;
  assign height_eff = (height_r == '0) ? irb_pkg::DIM_W'(1) :
                      (height_r > irb_pkg::DIM_W'(irb_pkg::MAX_HEIGHT)) ?
                      irb_pkg::DIM_W'(irb_pkg::MAX_HEIGHT) : height_r;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  assign in_item.op  = in_tuser;
  assign in_item.row = in_tdata[7:0];
  assign in_item.col = in_tdata[15:8];
  assign in_item.rgb = in_tdata[39:16];

  irb_map u_map (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_tvalid),
    .in_item    (in_item),
    .width_cfg  (width_eff),
    .height_cfg (height_eff),
    .cos_cfg    (cos_r),
    .sin_cfg    (sin_r),
    .out_valid  (map_valid),
    .out_item   (map_item),
    .out_coords (map_coords)
  );

  irb_fetch u_fetch (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (en),
    .in_valid    (map_valid),
    .in_item     (map_item),
    .in_coords   (map_coords),
    .out_valid   (fet_valid),
    .out_op      (fet_op),
    .out_row     (fet_row),
    .out_col     (fet_col),
    .out_pix     (fet_pix),
    .out_weights (fet_wt)
  );

  irb_blend u_blend (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (fet_valid),
    .in_op      (fet_op),
    .in_row     (fet_row),
    .in_col     (fet_col),
    .in_pix     (fet_pix),
    .in_weights (fet_wt),
    .out_valid  (out_tvalid),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_argb   (out_argb)
  );

  assign out_tdata = {out_argb, out_col, out_row};

endmodule
